@@ rtl/core/cle_pkg.sv @@
// shared types and constants for the console line editor
// no dependencies
package cle_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	// received keys with a meaning of their own
	localparam logic [7:0] KEY_BACKSPACE = 8'h7f;
	localparam logic [7:0] KEY_CTRL_D    = 8'h04;
	localparam logic [7:0] KEY_CTRL_U    = 8'h15;

	// echo and stored characters
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

@@ rtl/core/cle_in_if.sv @@
// input channel of the console line editor: command and received byte
// no dependencies
interface cle_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

@@ rtl/core/cle_out_if.sv @@
// result channel of the console line editor: echo or read data
// depends on cle_pkg
interface cle_out_if;
	logic            valid;
	logic            ready;
	cle_pkg::kind_t  kind;
	logic [7:0]      out_byte;
	logic            last;

	modport source (output valid, output kind, output out_byte, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

@@ rtl/core/cle_ram.sv @@
// single-port line store, registered read
// no dependencies
module cle_ram #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/console_line_editor.sv @@
// console line editor: one item at a time. a plain byte is stored, a read returns one committed
// byte or an empty result, ctrl-d commits the line, backspace echoes bs, space, bs, and ctrl-u
// erases back to the commit point or past a stored line break, then echoes space and bs. results
// leave through one output register; ctrl-u reads back each erased byte from the line store.
// arst_n clears the pointers, the sequencer and the output valid; the line store is not cleared.
// depends on cle_pkg, cle_in_if, cle_out_if, cle_ram
module console_line_editor #(
	parameter int DEPTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	cle_in_if.sink     req,
	cle_out_if.source  rsp
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_DATA,
		S_ONE,
		S_ERASE_BS,
		S_KILL_STEP,
		S_KILL_CHK,
		S_TAIL_SP,
		S_TAIL_BS
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   edit_q;
	logic [PTR_W-1:0]   commit_q;
	logic [PTR_W-1:0]   rd_q;
	cle_pkg::kind_t     pend_kind_q;
	logic [7:0]         pend_byte_q;
	logic               out_valid_q;
	cle_pkg::kind_t     out_kind_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic               accept;
	logic               slot_free;
	logic [PTR_W-1:0]   edit_inc;
	logic [PTR_W-1:0]   edit_dec;
	logic [PTR_W-1:0]   rd_inc;
	logic               full;
	logic               is_ctrl_d;
	logic               is_ctrl_u;
	logic               is_bs;
	logic               push;
	cle_pkg::kind_t     push_kind;
	logic [7:0]         push_byte;
	logic               push_last;
	logic               ram_we;
	logic               ram_re;
	logic [PTR_W-1:0]   ram_addr;
	logic [7:0]         ram_rdata;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;

	assign edit_inc = (edit_q == PTR_MAX) ? '0 : edit_q + PTR_W'(1);
	assign edit_dec = (edit_q == '0) ? PTR_MAX : edit_q - PTR_W'(1);
	assign rd_inc   = (rd_q == PTR_MAX) ? '0 : rd_q + PTR_W'(1);
	// one cell stays free, so a full ring has the edit pointer right behind the read pointer
	assign full     = (edit_inc == rd_q);

	assign is_ctrl_d = (req.rx_byte == cle_pkg::KEY_CTRL_D);
	assign is_ctrl_u = (req.rx_byte == cle_pkg::KEY_CTRL_U);
	assign is_bs     = (req.rx_byte == cle_pkg::KEY_BACKSPACE);

	always_comb begin
		push      = 1'b0;
		push_kind = cle_pkg::KIND_ECHO;
		push_byte = cle_pkg::CH_BS;
		push_last = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = edit_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.command) begin
						if (rd_q != commit_q) begin
							ram_re   = 1'b1;
							ram_addr = rd_q;
						end
					end else if (!is_ctrl_d && !is_ctrl_u && !is_bs && !full) begin
						ram_we = 1'b1;
					end
				end
			end
			S_RD_DATA: begin
				push      = slot_free;
				push_kind = cle_pkg::KIND_DATA;
				push_byte = ram_rdata;
				push_last = 1'b1;
			end
			S_ONE: begin
				push      = slot_free;
				push_kind = pend_kind_q;
				push_byte = pend_byte_q;
				push_last = 1'b1;
			end
			S_ERASE_BS: begin
				push = slot_free;
			end
			S_KILL_STEP: begin
				if (edit_q != commit_q && slot_free) begin
					push     = 1'b1;
					ram_re   = 1'b1;
					ram_addr = edit_dec;
				end
			end
			S_KILL_CHK: begin
			end
			S_TAIL_SP: begin
				push      = slot_free;
				push_byte = cle_pkg::CH_SPACE;
			end
			S_TAIL_BS: begin
				push      = slot_free;
				push_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	cle_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (req.rx_byte),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			edit_q      <= '0;
			commit_q    <= '0;
			rd_q        <= '0;
			pend_kind_q <= cle_pkg::KIND_ECHO;
			pend_byte_q <= cle_pkg::CH_NUL;
			out_valid_q <= 1'b0;
			out_kind_q  <= cle_pkg::KIND_ECHO;
			out_byte_q  <= cle_pkg::CH_NUL;
			out_last_q  <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= push_kind;
				out_byte_q  <= push_byte;
				out_last_q  <= push_last;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command) begin
							if (rd_q != commit_q) begin
								state_q <= S_RD_DATA;
							end else begin
								pend_kind_q <= cle_pkg::KIND_EMPTY;
								pend_byte_q <= cle_pkg::CH_NUL;
								state_q     <= S_ONE;
							end
						end else if (is_ctrl_d) begin
							if (!full) begin
								commit_q    <= edit_q;
								pend_kind_q <= cle_pkg::KIND_ECHO;
								pend_byte_q <= cle_pkg::KEY_CTRL_D;
								state_q     <= S_ONE;
							end
						end else if (is_ctrl_u) begin
							state_q <= S_KILL_STEP;
						end else if (is_bs) begin
							if (edit_q != commit_q) begin
								edit_q  <= edit_dec;
								state_q <= S_ERASE_BS;
							end
						end else if (!full) begin
							edit_q <= edit_inc;
						end
					end
				end
				S_RD_DATA: begin
					if (push) begin
						rd_q    <= rd_inc;
						state_q <= S_IDLE;
					end
				end
				S_ONE: begin
					if (push) begin
						state_q <= S_IDLE;
					end
				end
				S_ERASE_BS: begin
					if (push) begin
						state_q <= S_TAIL_SP;
					end
				end
				S_KILL_STEP: begin
					if (edit_q == commit_q) begin
						state_q <= S_TAIL_SP;
					end else if (push) begin
						edit_q  <= edit_dec;
						state_q <= S_KILL_CHK;
					end
				end
				S_KILL_CHK: begin
					// stop right after erasing a stored newline or ctrl-d
					if (ram_rdata == cle_pkg::CH_NL || ram_rdata == cle_pkg::KEY_CTRL_D) begin
						state_q <= S_TAIL_SP;
					end else begin
						state_q <= S_KILL_STEP;
					end
				end
				S_TAIL_SP: begin
					if (push) begin
						state_q <= S_TAIL_BS;
					end
				end
				S_TAIL_BS: begin
					if (push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.kind     = out_kind_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.last     = out_last_q;

`ifndef SYNTHESIS
	// pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(edit_q <= PTR_MAX) && (commit_q <= PTR_MAX) && (rd_q <= PTR_MAX))
		else $error("line pointer outside the ring");

	// a data read never runs past the committed bytes
	a_read_committed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_DATA) |-> (rd_q != commit_q))
		else $error("read of an uncommitted cell");

	// the final result of an item returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_last) |=> (state_q == S_IDLE))
		else $error("sequencer busy after final beat");

	// erasing never steps the edit pointer past the commit point
	a_kill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KILL_STEP && push) |-> (edit_q != commit_q))
		else $error("erase beyond commit point");
`endif

endmodule
